// ===== sv/staging_ring_allocator_top_macros.svh =====
// Assertion macros for the staging ring allocator.
// Used by modules that check their own logic; expects i_clk and i_rst_n in scope.
`ifndef STAGING_RING_ALLOCATOR_TOP_MACROS_SVH
`define STAGING_RING_ALLOCATOR_TOP_MACROS_SVH

// condition holds in the same cycle
`define SRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sra_pkg.sv =====
// Shared constants and types for the staging ring allocator.
// No dependencies; imported by sra_fifo, staging_ring_allocator_top and the testbench.
package sra_pkg;

    localparam int ALIGN_BYTES    = 16;
    localparam int MAX_IN_FLIGHT  = 8;
    localparam int RING_ADDR_BITS = 16;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 17;
    localparam int CAP_W      = 17;
    localparam int STATUS_W   = 3;
    localparam int OFFSET_W   = 16;
    localparam int SERIAL_W   = 32;
    localparam int BYTES_W    = 17;
    localparam int INFLIGHT_W = 4;

    // pointers and byte counts hold 0 .. 2^RING_ADDR_BITS (and saturate one bit wider)
    localparam int PTR_W = RING_ADDR_BITS + 1;
    localparam int SUM_W = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

    localparam int FIFO_IDX_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
    localparam int FIFO_CNT_W = $clog2(MAX_IN_FLIGHT + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETIRE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_RING_FULL = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_FIFO_FULL = 3'd3,
        ST_NONE      = 3'd4
    } t_status;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [PTR_W-1:0]    ring_end;
        logic [PTR_W-1:0]    byte_count;
    } t_fifo_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  full;
        logic                  empty;
    } t_fifo_stat;

endpackage

// ===== sv/sra_fifo.sv =====
// In-flight batch queue: serial, ring end and byte count per flushed batch.
// Depends on sra_pkg and staging_ring_allocator_top_macros.svh.
`include "staging_ring_allocator_top_macros.svh"

module sra_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sra_pkg::t_fifo_ctl   i_ctl,
    input  sra_pkg::t_fifo_entry i_wr_entry,
    output sra_pkg::t_fifo_entry o_rd_entry,
    output sra_pkg::t_fifo_stat  o_stat
);
    import sra_pkg::*;

    t_fifo_entry           r_mem [MAX_IN_FLIGHT];
    logic [FIFO_IDX_W-1:0] r_rd_idx;
    logic [FIFO_IDX_W-1:0] r_wr_idx;
    logic [FIFO_CNT_W-1:0] r_count;

    function automatic logic [FIFO_IDX_W-1:0] idx_inc(input logic [FIFO_IDX_W-1:0] idx);
        return (idx == FIFO_IDX_W'(MAX_IN_FLIGHT - 1)) ? '0 : idx + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_idx] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_idx <= idx_inc(r_wr_idx);
            end
            if (i_ctl.pop) begin
                r_rd_idx <= idx_inc(r_rd_idx);
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_entry   = r_mem[r_rd_idx];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == FIFO_CNT_W'(MAX_IN_FLIGHT));
    assign o_stat.empty = (r_count == '0);

    `SRA_ASSERT_NOW(a_push_not_full, i_ctl.push, !o_stat.full, "push into full batch queue")
    `SRA_ASSERT_NOW(a_pop_not_empty, i_ctl.pop, !o_stat.empty, "pop from empty batch queue")
    `SRA_ASSERT_NEXT(a_push_count, i_ctl.push && !i_ctl.pop, r_count == $past(r_count) + 1'b1, "count did not grow on push")
    `SRA_ASSERT_NEXT(a_ptr_gap, i_ctl.pop && !i_ctl.push, r_rd_idx != $past(r_rd_idx) || MAX_IN_FLIGHT == 1, "read index stuck on pop")

endmodule

// ===== sv/staging_ring_allocator_top.sv =====
// Staging ring allocator: aligned span allocation over a circular ring with in-order release.
// Depends on sra_pkg and sra_fifo.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------------------
//   request   | start, busy                | i_mode, i_size
//   result    | o_valid (one-cycle strobe) | o_status, o_offset, o_wrapped,
//             |                            | o_ticket_serial, o_completed_serial,
//             |                            | o_bytes_in_use, o_batches_in_flight
//   config    | i_cfg_valid, o_cfg_ready   | i_cfg_data (ring capacity)
//
// One request per cycle; busy stays low. A taken request is captured in the request register,
// evaluated against the pointer state in the next cycle, and its result strobes on o_valid
// once it is loaded into the result register.
// Synchronous active-low reset clears pointers, serials and the batch queue; next serial -> 1, capacity -> 65536.
// The receiver cannot stall; o_cfg_ready drops while a request is being evaluated.
module staging_ring_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sra_pkg::MODE_W-1:0]      i_mode,
    input  logic [sra_pkg::SIZE_W-1:0]      i_size,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sra_pkg::CAP_W-1:0]       i_cfg_data,
    output logic                            o_valid,
    output logic [sra_pkg::STATUS_W-1:0]    o_status,
    output logic [sra_pkg::OFFSET_W-1:0]    o_offset,
    output logic                            o_wrapped,
    output logic [sra_pkg::SERIAL_W-1:0]    o_ticket_serial,
    output logic [sra_pkg::SERIAL_W-1:0]    o_completed_serial,
    output logic [sra_pkg::BYTES_W-1:0]     o_bytes_in_use,
    output logic [sra_pkg::INFLIGHT_W-1:0]  o_batches_in_flight
);
    import sra_pkg::*;

    localparam logic [PTR_W-1:0] CAP_LIM    = PTR_W'(1) << RING_ADDR_BITS;
    localparam logic [SUM_W-1:0] ALIGN_MASK = SUM_W'(ALIGN_BYTES - 1);

    // request register
    logic              r_req_valid;
    logic [MODE_W-1:0] r_req_mode;
    logic [SIZE_W-1:0] r_req_size;

    // configuration and ring state
    logic [CAP_W-1:0]    r_capacity;
    logic [PTR_W-1:0]    r_head,          n_head;
    logic [PTR_W-1:0]    r_tail,          n_tail;
    logic [PTR_W-1:0]    r_used,          n_used;
    logic [PTR_W-1:0]    r_open_bytes,    n_open_bytes;
    logic [SERIAL_W-1:0] r_open_serial,   n_open_serial;
    logic [SERIAL_W-1:0] r_next_serial,   n_next_serial;
    logic [SERIAL_W-1:0] r_last_sub,      n_last_sub;
    logic [SERIAL_W-1:0] r_completed,     n_completed;

    // result register
    logic                r_res_valid;
    t_status             r_res_status,    n_res_status;
    logic [OFFSET_W-1:0] r_res_offset,    n_res_offset;
    logic                r_res_wrapped,   n_res_wrapped;
    logic [SERIAL_W-1:0] r_res_ticket,    n_res_ticket;

    t_fifo_ctl   fifo_ctl;
    t_fifo_entry fifo_wr;
    t_fifo_entry fifo_rd;
    t_fifo_stat  fifo_stat;

    // allocation datapath
    logic [PTR_W-1:0] cap;
    logic [SUM_W-1:0] head_plus;
    logic             size_bad;
    logic             alloc_ok;
    logic             base_zero;
    logic             pad_path;
    logic             alloc_wrap;
    logic             ring_empty;
    logic [PTR_W-1:0] base;
    logic [PTR_W-1:0] new_head;
    logic [PTR_W-1:0] take;
    logic [PTR_W-1:0] retire_used;

    function automatic logic [PTR_W-1:0] sat_sub(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [PTR_W-1:0] sat_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PTR_W] ? '1 : s[PTR_W-1:0];
    endfunction

    // round the span end up to the alignment, never past the ring capacity
    function automatic logic [PTR_W-1:0] align_cap(input logic [SUM_W-1:0] v,
                                                   input logic [PTR_W-1:0] c);
        logic [SUM_W-1:0] r;
        r = (v + ALIGN_MASK) & ~ALIGN_MASK;
        return (r > SUM_W'(c)) ? c : PTR_W'(r);
    endfunction

    sra_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (fifo_ctl),
        .i_wr_entry (fifo_wr),
        .o_rd_entry (fifo_rd),
        .o_stat     (fifo_stat)
    );

    assign busy        = 1'b0;
    assign o_cfg_ready = !r_req_valid;

    // effective capacity saturates at the ring address space
    assign cap = (SUM_W'(r_capacity) > SUM_W'(CAP_LIM)) ? CAP_LIM : PTR_W'(r_capacity);

    always_comb begin
        head_plus  = SUM_W'(r_head) + SUM_W'(r_req_size);
        size_bad   = (r_req_size == '0) || (SUM_W'(r_req_size) > SUM_W'(cap));
        ring_empty = (r_used == '0);
        alloc_ok   = 1'b0;
        base_zero  = 1'b0;
        pad_path   = 1'b0;
        alloc_wrap = 1'b0;
        if (ring_empty) begin
            alloc_ok = 1'b1;
            if (head_plus > SUM_W'(cap)) begin
                base_zero  = 1'b1;
                alloc_wrap = (r_head != '0);
            end
        end else if (r_head > r_tail) begin
            if (head_plus <= SUM_W'(cap)) begin
                alloc_ok = 1'b1;
            end else if (SUM_W'(r_req_size) <= SUM_W'(r_tail)) begin
                // wrap to ring start, the end of the ring counts as padding
                alloc_ok   = 1'b1;
                base_zero  = 1'b1;
                pad_path   = 1'b1;
                alloc_wrap = 1'b1;
            end
        end else if (r_head < r_tail) begin
            alloc_ok = (head_plus <= SUM_W'(r_tail));
        end
        base     = base_zero ? '0 : r_head;
        new_head = align_cap(SUM_W'(base) + SUM_W'(r_req_size), cap);
        take     = pad_path ? sat_add(sat_sub(cap, r_head), new_head) : sat_sub(new_head, base);
    end

    assign retire_used = sat_sub(r_used, fifo_rd.byte_count);

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_used        = r_used;
        n_open_bytes  = r_open_bytes;
        n_open_serial = r_open_serial;
        n_next_serial = r_next_serial;
        n_last_sub    = r_last_sub;
        n_completed   = r_completed;
        n_res_status  = ST_OK;
        n_res_offset  = '0;
        n_res_wrapped = 1'b0;
        n_res_ticket  = r_open_serial;
        fifo_ctl      = '0;
        fifo_wr.serial     = r_open_serial;
        fifo_wr.ring_end   = r_head;
        fifo_wr.byte_count = r_open_bytes;

        case (r_req_mode)
            MODE_ALLOC: begin
                if (size_bad) begin
                    n_res_status = ST_BAD_SIZE;
                end else if (!alloc_ok) begin
                    n_res_status = ST_RING_FULL;
                end else begin
                    n_head        = new_head;
                    n_used        = sat_add(r_used, take);
                    n_open_bytes  = sat_add(r_open_bytes, take);
                    n_res_offset  = OFFSET_W'(base);
                    n_res_wrapped = alloc_wrap;
                    if (ring_empty) begin
                        n_tail = base;
                    end
                    if (r_open_serial == '0) begin
                        n_open_serial = r_next_serial;
                        // serials skip zero on wrap
                        n_next_serial = (r_next_serial == '1) ? SERIAL_W'(1)
                                                              : r_next_serial + 1'b1;
                    end
                    n_res_ticket = n_open_serial;
                end
            end
            MODE_FLUSH: begin
                if (r_open_serial == '0) begin
                    n_res_ticket = r_last_sub;
                end else if (fifo_stat.full) begin
                    n_res_status = ST_FIFO_FULL;
                end else begin
                    fifo_ctl.push = 1'b1;
                    n_last_sub    = r_open_serial;
                    n_open_serial = '0;
                    n_open_bytes  = '0;
                end
            end
            MODE_RETIRE: begin
                if (fifo_stat.empty) begin
                    n_res_status = ST_NONE;
                end else begin
                    fifo_ctl.pop = 1'b1;
                    n_used       = retire_used;
                    n_tail       = (retire_used == '0) ? r_head : fifo_rd.ring_end;
                    n_completed  = fifo_rd.serial;
                end
            end
            default: begin
                // unused mode: report the current state
                n_res_status = ST_OK;
            end
        endcase

        if (!r_req_valid) begin
            fifo_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req_mode <= i_mode;
            r_req_size <= i_size;
        end
        if (r_req_valid) begin
            r_res_status  <= n_res_status;
            r_res_offset  <= n_res_offset;
            r_res_wrapped <= n_res_wrapped;
            r_res_ticket  <= n_res_ticket;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid   <= 1'b0;
            r_res_valid   <= 1'b0;
            r_capacity    <= CAP_RESET;
            r_head        <= '0;
            r_tail        <= '0;
            r_used        <= '0;
            r_open_bytes  <= '0;
            r_open_serial <= '0;
            r_next_serial <= SERIAL_W'(1);
            r_last_sub    <= '0;
            r_completed   <= '0;
        end else begin
            r_req_valid <= start && !busy;
            r_res_valid <= r_req_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (r_req_valid) begin
                r_head        <= n_head;
                r_tail        <= n_tail;
                r_used        <= n_used;
                r_open_bytes  <= n_open_bytes;
                r_open_serial <= n_open_serial;
                r_next_serial <= n_next_serial;
                r_last_sub    <= n_last_sub;
                r_completed   <= n_completed;
            end
        end
    end

    // completed, used and in-flight count only change at the edge that loads a result,
    // so the state registers carry those fields for the strobe cycle
    assign o_valid             = r_res_valid;
    assign o_status            = r_res_status;
    assign o_offset            = r_res_offset;
    assign o_wrapped           = r_res_wrapped;
    assign o_ticket_serial     = r_res_ticket;
    assign o_completed_serial  = r_completed;
    assign o_bytes_in_use      = BYTES_W'(r_used);
    assign o_batches_in_flight = INFLIGHT_W'(fifo_stat.count);

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for staging_ring_allocator_top: directed table, then random phases.
// Depends on sra_pkg; an internal predictor tracks ring pointers, serials and the batch queue.
module testbench;
    import sra_pkg::*;

    localparam int WIDE_W       = SUM_W + 1;
    localparam int PHASES       = 9;
    localparam int PER_PHASE    = 67;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef logic [WIDE_W-1:0] t_wide;
    localparam t_wide CAP_LIMIT = t_wide'(1) << RING_ADDR_BITS;
    localparam t_wide BYTES_MAX = (t_wide'(1) << PTR_W) - 1'b1;

    localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] = '{
        17'd1000, 17'd1, 17'd0, 17'h1FFFF, 17'd65535, 17'd4096, 17'd65536, 17'd300, 17'd0
    };

    typedef struct packed {
        t_status                status;
        logic [OFFSET_W-1:0]    offset;
        logic                   wrapped;
        logic [SERIAL_W-1:0]    ticket;
        logic [SERIAL_W-1:0]    completed;
        logic [BYTES_W-1:0]     bytes;
        logic [INFLIGHT_W-1:0]  inflight;
    } t_ring_result;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size;
        bit                typed;
        t_ring_result      want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [MODE_W-1:0]      i_mode = '0;
    logic [SIZE_W-1:0]      i_size = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CAP_W-1:0]       i_cfg_data = '0;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [OFFSET_W-1:0]    o_offset;
    logic                   o_wrapped;
    logic [SERIAL_W-1:0]    o_ticket_serial;
    logic [SERIAL_W-1:0]    o_completed_serial;
    logic [BYTES_W-1:0]     o_bytes_in_use;
    logic [INFLIGHT_W-1:0]  o_batches_in_flight;

    // predictor state
    logic [CAP_W-1:0]       ring_capacity = CAP_RESET;
    t_wide                  ring_head = '0;
    t_wide                  ring_tail = '0;
    t_wide                  ring_used = '0;
    logic [SERIAL_W-1:0]    open_ticket = '0;
    t_wide                  open_span_bytes = '0;
    logic [SERIAL_W-1:0]    ticket_counter = 32'd1;
    logic [SERIAL_W-1:0]    last_flushed = '0;
    logic [SERIAL_W-1:0]    retired_ticket = '0;
    logic [SERIAL_W-1:0]    batch_serial [MAX_IN_FLIGHT];
    t_wide                  batch_end [MAX_IN_FLIGHT];
    t_wide                  batch_bytes [MAX_IN_FLIGHT];
    logic [FIFO_IDX_W-1:0]  batch_rd = '0;
    logic [FIFO_CNT_W-1:0]  batch_count = '0;

    t_ring_result  pending_results [$];
    t_ring_result  oldest;
    t_stim_row     directed_rows [$];
    int            mismatch_count = 0;

    staging_ring_allocator_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_size              (i_size),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_offset            (o_offset),
        .o_wrapped           (o_wrapped),
        .o_ticket_serial     (o_ticket_serial),
        .o_completed_serial  (o_completed_serial),
        .o_bytes_in_use      (o_bytes_in_use),
        .o_batches_in_flight (o_batches_in_flight)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_wide sat_diff(t_wide a, t_wide b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic t_wide sat_sum(t_wide a, t_wide b);
        t_wide s;
        s = a + b;
        return (s > BYTES_MAX) ? BYTES_MAX : s;
    endfunction

    // round a span end up to the alignment, never past the ring end
    function automatic t_wide round_up(t_wide v, t_wide cap);
        t_wide r;
        r = t_wide'(((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
        return (r > cap) ? cap : r;
    endfunction

    function automatic t_wide usable_capacity();
        return (t_wide'(ring_capacity) > CAP_LIMIT) ? CAP_LIMIT : t_wide'(ring_capacity);
    endfunction

    task automatic grow_open_span(t_wide n);
        ring_used       = sat_sum(ring_used, n);
        open_span_bytes = sat_sum(open_span_bytes, n);
    endtask

    task automatic predict_ring_event(input logic [MODE_W-1:0] mode,
                                      input logic [SIZE_W-1:0] size,
                                      output t_ring_result res);
        t_wide cap;
        t_wide sz;
        t_wide base;
        t_wide nh;
        logic [FIFO_IDX_W-1:0] slot;
        res        = '0;
        res.status = ST_OK;
        cap        = usable_capacity();
        sz         = t_wide'(size);
        case (mode)
            MODE_ALLOC: begin
                if (sz == 0 || sz > cap) begin
                    res.status = ST_BAD_SIZE;
                end else if (ring_used == 0) begin
                    // empty ring: restart at head, or at zero when it does not fit
                    base = ring_head;
                    if (ring_head + sz > cap) begin
                        res.wrapped = (ring_head != 0);
                        base = '0;
                    end
                    nh              = round_up(base + sz, cap);
                    ring_tail       = base;
                    ring_used       = sat_diff(nh, base);
                    open_span_bytes = sat_sum(open_span_bytes, ring_used);
                    ring_head       = nh;
                    res.offset      = OFFSET_W'(base);
                end else if (ring_head == ring_tail) begin
                    res.status = ST_RING_FULL;
                end else if (ring_head > ring_tail) begin
                    if (ring_head + sz <= cap) begin
                        nh = round_up(ring_head + sz, cap);
                        grow_open_span(sat_diff(nh, ring_head));
                        res.offset = OFFSET_W'(ring_head);
                        ring_head  = nh;
                    end else if (sz <= ring_tail) begin
                        // padding to the ring end is charged to the open batch
                        nh = round_up(sz, cap);
                        grow_open_span(sat_sum(sat_diff(cap, ring_head), nh));
                        res.wrapped = 1'b1;
                        ring_head   = nh;
                    end else begin
                        res.status = ST_RING_FULL;
                    end
                end else if (ring_head + sz <= ring_tail) begin
                    nh = round_up(ring_head + sz, cap);
                    grow_open_span(sat_diff(nh, ring_head));
                    res.offset = OFFSET_W'(ring_head);
                    ring_head  = nh;
                end else begin
                    res.status = ST_RING_FULL;
                end
                if (res.status == ST_OK && open_ticket == 0) begin
                    open_ticket    = ticket_counter;
                    ticket_counter = ticket_counter + 1'b1;
                    if (ticket_counter == 0) ticket_counter = 32'd1;
                end
                res.ticket = open_ticket;
            end
            MODE_FLUSH: begin
                if (open_ticket == 0) begin
                    res.ticket = last_flushed;
                end else if (batch_count >= MAX_IN_FLIGHT) begin
                    res.status = ST_FIFO_FULL;
                    res.ticket = open_ticket;
                end else begin
                    slot               = FIFO_IDX_W'((batch_rd + batch_count) % MAX_IN_FLIGHT);
                    batch_serial[slot] = open_ticket;
                    batch_end[slot]    = ring_head;
                    batch_bytes[slot]  = open_span_bytes;
                    batch_count        = batch_count + 1'b1;
                    last_flushed       = open_ticket;
                    res.ticket         = open_ticket;
                    open_ticket        = '0;
                    open_span_bytes    = '0;
                end
            end
            MODE_RETIRE: begin
                if (batch_count == 0) begin
                    res.status = ST_NONE;
                end else begin
                    ring_used = sat_diff(ring_used, batch_bytes[batch_rd]);
                    ring_tail = batch_end[batch_rd];
                    if (ring_used == 0) ring_tail = ring_head;
                    retired_ticket = batch_serial[batch_rd];
                    batch_rd       = FIFO_IDX_W'((batch_rd + 1) % MAX_IN_FLIGHT);
                    batch_count    = batch_count - 1'b1;
                end
                res.ticket = open_ticket;
            end
            default: begin
                res.ticket = open_ticket;
            end
        endcase
        res.completed = retired_ticket;
        res.bytes     = BYTES_W'(ring_used);
        res.inflight  = batch_count;
    endtask

    task automatic flag_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h", field, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                           input bit typed, input t_ring_result want);
        t_stim_row row;
        row.mode  = mode;
        row.size  = size;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // start is left high; whoever idles next lowers it
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                                input bit typed, input t_ring_result want);
        t_ring_result predicted;
        start  <= 1'b1;
        i_mode <= mode;
        i_size <= size;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_ring_event(mode, size, predicted);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic sender_gap(input int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        ring_capacity = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(t_wide cap);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return SIZE_W'(cap);
            2:       return SIZE_W'(cap + 1'b1);
            3:       return SIZE_W'($urandom);
            4:       return SIZE_W'($urandom_range(1, (cap == 0) ? 1 : cap));
            default: return SIZE_W'($urandom_range(1, cap / 6 + 1));
        endcase
    endfunction

    // each result is compared with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no request pending", o_status, 0);
            end else begin
                oldest = pending_results[0];
                pending_results.delete(0);
                if (o_status !== oldest.status)
                    flag_mismatch("status", o_status, oldest.status);
                if (o_offset !== oldest.offset)
                    flag_mismatch("offset", o_offset, oldest.offset);
                if (o_wrapped !== oldest.wrapped)
                    flag_mismatch("wrapped", o_wrapped, oldest.wrapped);
                if (o_ticket_serial !== oldest.ticket)
                    flag_mismatch("ticket_serial", o_ticket_serial, oldest.ticket);
                if (o_completed_serial !== oldest.completed)
                    flag_mismatch("completed_serial", o_completed_serial, oldest.completed);
                if (o_bytes_in_use !== oldest.bytes)
                    flag_mismatch("bytes_in_use", o_bytes_in_use, oldest.bytes);
                if (o_batches_in_flight !== oldest.inflight)
                    flag_mismatch("batches_in_flight", o_batches_in_flight, oldest.inflight);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [MODE_W-1:0] mode;
        logic [CAP_W-1:0]  cap_value;
        int                sent;
        int                idle_pct;
        int                pick;

        // fresh ring: empty queue, nothing open, full capacity
        add_row(MODE_RETIRE, '0, 1'b1, '{ST_NONE, 16'd0, 1'b0, 32'd0, 32'd0, 17'd0, 4'd0});
        add_row(MODE_FLUSH, '0, 1'b1, '{ST_OK, 16'd0, 1'b0, 32'd0, 32'd0, 17'd0, 4'd0});
        add_row(MODE_ALLOC, '0, 1'b1, '{ST_BAD_SIZE, 16'd0, 1'b0, 32'd0, 32'd0, 17'd0, 4'd0});
        add_row(MODE_ALLOC, 17'd65537, 1'b1,
                '{ST_BAD_SIZE, 16'd0, 1'b0, 32'd0, 32'd0, 17'd0, 4'd0});
        add_row(MODE_IGNORED, 17'h1FFFF, 1'b1,
                '{ST_OK, 16'd0, 1'b0, 32'd0, 32'd0, 17'd0, 4'd0});
        add_row(MODE_ALLOC, 17'd65536, 1'b1,
                '{ST_OK, 16'd0, 1'b0, 32'd1, 32'd0, 17'd65536, 4'd0});
        add_row(MODE_ALLOC, 17'd1, 1'b1,
                '{ST_RING_FULL, 16'd0, 1'b0, 32'd1, 32'd0, 17'd65536, 4'd0});
        add_row(MODE_FLUSH, '0, 1'b1, '{ST_OK, 16'd0, 1'b0, 32'd1, 32'd0, 17'd65536, 4'd1});
        add_row(MODE_RETIRE, '0, 1'b1, '{ST_OK, 16'd0, 1'b0, 32'd0, 32'd1, 17'd0, 4'd0});
        // odd sizes exercise alignment; the first one wraps from the ring end
        add_row(MODE_ALLOC, 17'd1, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd15, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd16, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd17, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd31, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd33, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd100, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        add_row(MODE_ALLOC, 17'd4000, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);
        // batch queue is full now: the next flush is refused
        add_row(MODE_ALLOC, 17'd16, 1'b0, '0);
        add_row(MODE_FLUSH, '0, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            sender_gap(30);
            send_request(directed_rows[i].mode, directed_rows[i].size,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // capacity changes land on whatever the ring holds at that point
        for (int p = 0; p < PHASES; p++) begin
            cap_value = (p == PHASES - 1) ? CAP_W'($urandom_range(1, 65536)) : PHASE_CAPS[p];
            write_capacity(cap_value);
            idle_pct = (p == PHASES - 1) ? 0 : (p % 3) * 25;
            sent = 0;
            while (sent < PER_PHASE) begin
                if (p == 1 && sent == PER_PHASE / 2) drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 50)      mode = MODE_ALLOC;
                else if (pick < 70) mode = MODE_FLUSH;
                else if (pick < 95) mode = MODE_RETIRE;
                else                mode = MODE_IGNORED;
                sender_gap(idle_pct);
                send_request(mode, pick_size(usable_capacity()), 1'b0, '0);
                if (mode != MODE_IGNORED) sent++;
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sra_pkg.sv
sv/sra_fifo.sv
sv/staging_ring_allocator_top.sv
sim/testbench.sv
